@@ rtl/core/assert_macros.svh @@
// Assertion shorthands shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define MFEC_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define MFEC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/mfec_pkg.sv @@
`default_nettype none
package mfec_pkg;

   localparam int MAX_FACE_VERTICES = 16;
   localparam int VC_W = $clog2(MAX_FACE_VERTICES + 1);

   localparam logic [31:0] COSINE_RESET = 32'd929887697;

   typedef enum logic [1:0] {
      CLASS_BOUNDARY    = 2'd0,
      CLASS_NONMANIFOLD = 2'd1,
      CLASS_FEATURE     = 2'd2,
      CLASS_MANIFOLD    = 2'd3
   } edge_class_type;

   localparam logic [2:0] CSR_FEATURE_COSINE     = 3'd0;
   localparam logic [2:0] CSR_BOUNDARY_ENABLE    = 3'd1;
   localparam logic [2:0] CSR_NONMANIFOLD_ENABLE = 3'd2;
   localparam logic [2:0] CSR_FEATURE_ENABLE     = 3'd3;
   localparam logic [2:0] CSR_MANIFOLD_ENABLE    = 3'd4;

   typedef struct packed {
      logic [31:0]        edge_number;
      logic [3:0]         face_count;
      logic               face_select;
      logic signed [23:0] vertex_x;
      logic signed [23:0] vertex_y;
      logic signed [23:0] vertex_z;
      logic               face_end;
      logic               edge_end;
      logic [31:0]        endpoint_a;
      logic [31:0]        endpoint_b;
   } req_type;

   typedef struct packed {
      logic [31:0]    edge_out;
      logic [31:0]    point_a_out;
      logic [31:0]    point_b_out;
      edge_class_type edge_class;
   } rsp_type;

   // root/divide unit control
   typedef struct packed {
      logic        start;
      logic        is_div;
      logic [63:0] operand;
      logic [31:0] divisor;
   } rdu_cmd_type;

   typedef struct packed {
      logic        done;
      logic [31:0] result;
   } rdu_sts_type;

endpackage
`default_nettype wire

@@ rtl/core/mfec_root_div.sv @@
`default_nettype none
// Bit-serial unit: floor square root of a 64-bit value (32 steps) or
// quotient of a 62-bit numerator by a divisor known to exceed numerator>>31
// (31 steps). Result in result[31:0].
module mfec_root_div (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire mfec_pkg::rdu_cmd_type cmd,
   output mfec_pkg::rdu_sts_type      sts
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic        is_div_ff, is_div_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [35:0] rem_ff, rem_in;
   logic [63:0] x_ff, x_in;
   logic [31:0] q_ff, q_in;
   logic [31:0] div_ff, div_in;

   logic [35:0] rem_sh;
   logic [35:0] trial;
   logic        ge;

   always_comb begin
      rem_sh = is_div_ff ? {rem_ff[34:0], x_ff[63]} : {rem_ff[33:0], x_ff[63:62]};
      trial  = is_div_ff ? {4'b0, div_ff} : {2'b0, q_ff, 2'b01};
      ge     = rem_sh >= trial;

      busy_in   = busy_ff;
      done_in   = 1'b0;
      is_div_in = is_div_ff;
      cnt_in    = cnt_ff;
      rem_in    = rem_ff;
      x_in      = x_ff;
      q_in      = q_ff;
      div_in    = div_ff;

      if (cmd.start) begin
         busy_in   = 1'b1;
         is_div_in = cmd.is_div;
         div_in    = cmd.divisor;
         q_in      = '0;
         if (cmd.is_div) begin
            cnt_in = 6'd31;
            rem_in = {3'b0, cmd.operand[63:31]};
            x_in   = {cmd.operand[30:0], 33'b0};
         end else begin
            cnt_in = 6'd32;
            rem_in = '0;
            x_in   = cmd.operand;
         end
      end else if (busy_ff) begin
         rem_in = ge ? rem_sh - trial : rem_sh;
         q_in   = {q_ff[30:0], ge};
         x_in   = is_div_ff ? {x_ff[62:0], 1'b0} : {x_ff[61:0], 2'b0};
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      is_div_ff <= is_div_in;
      cnt_ff    <= cnt_in;
      rem_ff    <= rem_in;
      x_ff      <= x_in;
      q_ff      <= q_in;
      div_ff    <= div_in;
   end

   assign sts.done   = done_ff;
   assign sts.result = q_ff;

endmodule
`default_nettype wire

@@ rtl/core/mesh_feature_edge_classifier.sv @@
`default_nettype none
// Mesh edge classifier.
// req_*: one request per item (valid/ready). Edges with face_count other
//   than two are one request; two-face edges stream one vertex per request,
//   face 0 then face 1, face_end/edge_end closing a face.
// rsp_*: at most one response per edge (valid/ready), held in an output
//   register; class 0 boundary, 1 non-manifold, 2 feature, 3 manifold.
// csr_*: register writes, always ready; write only while idle.
// Flow: one request at a time, req_ready low while it is worked on.
//   A single-item edge goes straight to the final state. An open-face vertex
//   adds a Newell term unless it is the first or a dropped vertex.
//   A face close runs the one-bit-per-cycle normalizing shift of the Newell
//   sums, then the bit-serial root/divide unit (one square root, three
//   divides, one bit per cycle).
//   All products go through one registered 32x32 multiplier.
// Reset: configuration registers to defaults, face and edge state cleared, no response.
// A stalled receiver holds the response; the block waits in its final state
//   only if a new response is due while the old one is still held.
`include "assert_macros.svh"
module mesh_feature_edge_classifier (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire mfec_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output mfec_pkg::rsp_type      rsp_data,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [2:0]        csr_index,
   input  wire logic [31:0]       csr_data
);

   typedef enum logic [11:0] {
      ST_IDLE   = 12'b0000_0000_0001,
      ST_VERT   = 12'b0000_0000_0010,
      ST_TERM   = 12'b0000_0000_0100,
      ST_CLOSE  = 12'b0000_0000_1000,
      ST_MAG    = 12'b0000_0001_0000,
      ST_SHIFT  = 12'b0000_0010_0000,
      ST_SQ     = 12'b0000_0100_0000,
      ST_ROOT   = 12'b0000_1000_0000,
      ST_DIV    = 12'b0001_0000_0000,
      ST_EDGE   = 12'b0010_0000_0000,
      ST_DOT    = 12'b0100_0000_0000,
      ST_FINISH = 12'b1000_0000_0000
   } state_type;

   localparam logic [mfec_pkg::VC_W-1:0] VC_MAX =
      mfec_pkg::VC_W'(mfec_pkg::MAX_FACE_VERTICES);
   localparam logic [mfec_pkg::VC_W-1:0] VC_MIN_FACE = mfec_pkg::VC_W'(3);
   localparam logic signed [63:0] DOT_ONE = 64'sd1 <<< 60;

   state_type state_ff, state_in;

   // configuration
   logic [31:0] cos_ff, cos_in;
   logic        be_ff, be_in, ne_ff, ne_in, fe_ff, fe_in, me_ff, me_in;

   // edge and face state
   logic signed [55:0] acc_ff [3];
   logic signed [55:0] acc_in [3];
   logic signed [23:0] first_ff [3];
   logic signed [23:0] first_in [3];
   logic signed [23:0] prev_ff [3];
   logic signed [23:0] prev_in [3];
   logic signed [31:0] saved_ff [3];
   logic signed [31:0] saved_in [3];
   logic [mfec_pkg::VC_W-1:0] vc_ff, vc_in;
   logic ffd_ff, ffd_in;

   // working registers
   mfec_pkg::req_type item_ff, item_in;
   logic [55:0]        mag_ff [3];
   logic [55:0]        mag_in [3];
   logic [2:0]         neg_ff, neg_in;
   logic signed [31:0] unit_ff [3];
   logic signed [31:0] unit_in [3];
   logic [63:0]        sum_ff, sum_in;
   logic [31:0]        len_ff, len_in;
   logic signed [63:0] dot_ff, dot_in;
   logic signed [63:0] prod_ff;
   logic [1:0]         ph_ff, ph_in;
   logic [1:0]         idx_ff, idx_in;
   logic               term_close_ff, term_close_in;
   logic               face_ok_ff, face_ok_in;
   logic               have_dot_ff, have_dot_in;
   logic               start_ff, start_in;

   // response
   logic              rsp_valid_ff, rsp_valid_in;
   mfec_pkg::rsp_type rsp_ff, rsp_in;

   // combinational
   logic signed [23:0] vtx [3];
   logic signed [23:0] q_vec [3];
   logic signed [24:0] t_diff, t_sum;
   logic signed [31:0] mul_a, mul_b;
   logic [1:0]         acc_idx;
   logic [55:0]        mag_or;
   logic [61:0]        div_num;
   logic [31:0]        quo;
   logic signed [63:0] dot_cl, cos_ext;
   logic               cls_valid;
   mfec_pkg::edge_class_type cls;
   logic               first_ok;
   mfec_pkg::rdu_cmd_type rdu_cmd;
   mfec_pkg::rdu_sts_type rdu_sts;

   mfec_root_div u_root_div (
      .clock (clock),
      .reset (reset),
      .cmd   (rdu_cmd),
      .sts   (rdu_sts)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      vtx[0] = item_ff.vertex_x;
      vtx[1] = item_ff.vertex_y;
      vtx[2] = item_ff.vertex_z;
      for (int i = 0; i < 3; i++) q_vec[i] = term_close_ff ? first_ff[i] : vtx[i];
      acc_idx = ph_ff - 2'd1;
      mag_or  = mag_ff[0] | mag_ff[1] | mag_ff[2];
      div_num = {mag_ff[idx_ff][31:0], 30'b0} + {31'b0, len_ff[31:1]};
      quo     = {1'b0, rdu_sts.result[30:0]};
      first_ok = !ffd_ff && ((saved_ff[0] | saved_ff[1] | saved_ff[2]) != 32'sd0);

      // Newell term operands for the component in ph
      case (ph_ff)
         2'd0: begin
            t_diff = 25'(prev_ff[1]) - 25'(q_vec[1]);
            t_sum  = 25'(prev_ff[2]) + 25'(q_vec[2]);
         end
         2'd1: begin
            t_diff = 25'(prev_ff[2]) - 25'(q_vec[2]);
            t_sum  = 25'(prev_ff[0]) + 25'(q_vec[0]);
         end
         2'd2: begin
            t_diff = 25'(prev_ff[0]) - 25'(q_vec[0]);
            t_sum  = 25'(prev_ff[1]) + 25'(q_vec[1]);
         end
         default: begin
            t_diff = '0;
            t_sum  = '0;
         end
      endcase

      mul_a = '0;
      mul_b = '0;
      if (ph_ff != 2'd3) begin
         case (state_ff)
            ST_TERM: begin
               mul_a = 32'(t_diff);
               mul_b = 32'(t_sum);
            end
            ST_SQ: begin
               mul_a = {1'b0, mag_ff[ph_ff][30:0]};
               mul_b = {1'b0, mag_ff[ph_ff][30:0]};
            end
            ST_DOT: begin
               mul_a = saved_ff[ph_ff];
               mul_b = unit_ff[ph_ff];
            end
            default: begin
               mul_a = '0;
               mul_b = '0;
            end
         endcase
      end

      rdu_cmd.start   = start_ff;
      rdu_cmd.is_div  = (state_ff == ST_DIV);
      rdu_cmd.operand = (state_ff == ST_DIV) ? {2'b0, div_num} : sum_ff;
      rdu_cmd.divisor = len_ff;

      // classification of the finished edge
      if (dot_ff > DOT_ONE) begin
         dot_cl = DOT_ONE;
      end else if (dot_ff < -DOT_ONE) begin
         dot_cl = -DOT_ONE;
      end else begin
         dot_cl = dot_ff;
      end
      cos_ext = {{2{cos_ff[31]}}, cos_ff, 30'b0};
      cls_valid = 1'b0;
      cls       = mfec_pkg::CLASS_BOUNDARY;
      if (item_ff.face_count != 4'd2) begin
         if (item_ff.face_count == 4'd1 && be_ff) begin
            cls_valid = 1'b1;
            cls       = mfec_pkg::CLASS_BOUNDARY;
         end else if (item_ff.face_count >= 4'd3 && ne_ff) begin
            cls_valid = 1'b1;
            cls       = mfec_pkg::CLASS_NONMANIFOLD;
         end
      end else if (have_dot_ff) begin
         if (fe_ff && dot_cl <= cos_ext) begin
            cls_valid = 1'b1;
            cls       = mfec_pkg::CLASS_FEATURE;
         end else if (me_ff) begin
            cls_valid = 1'b1;
            cls       = mfec_pkg::CLASS_MANIFOLD;
         end
      end
   end

   always_comb begin
      state_in      = state_ff;
      cos_in        = cos_ff;
      be_in         = be_ff;
      ne_in         = ne_ff;
      fe_in         = fe_ff;
      me_in         = me_ff;
      acc_in        = acc_ff;
      first_in      = first_ff;
      prev_in       = prev_ff;
      saved_in      = saved_ff;
      vc_in         = vc_ff;
      ffd_in        = ffd_ff;
      item_in       = item_ff;
      mag_in        = mag_ff;
      neg_in        = neg_ff;
      unit_in       = unit_ff;
      sum_in        = sum_ff;
      len_in        = len_ff;
      dot_in        = dot_ff;
      ph_in         = ph_ff;
      idx_in        = idx_ff;
      term_close_in = term_close_ff;
      face_ok_in    = face_ok_ff;
      have_dot_in   = have_dot_ff;
      start_in      = 1'b0;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_in        = rsp_ff;

      if (csr_valid) begin
         case (csr_index)
            mfec_pkg::CSR_FEATURE_COSINE:     cos_in = csr_data;
            mfec_pkg::CSR_BOUNDARY_ENABLE:    be_in  = csr_data[0];
            mfec_pkg::CSR_NONMANIFOLD_ENABLE: ne_in  = csr_data[0];
            mfec_pkg::CSR_FEATURE_ENABLE:     fe_in  = csr_data[0];
            mfec_pkg::CSR_MANIFOLD_ENABLE:    me_in  = csr_data[0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               item_in     = req_data;
               have_dot_in = 1'b0;
               state_in    = (req_data.face_count == 4'd2) ? ST_VERT : ST_FINISH;
            end
         end

         ST_VERT: begin
            if (vc_ff == '0) begin
               first_in = vtx;
               prev_in  = vtx;
               vc_in    = mfec_pkg::VC_W'(1);
               state_in = ST_CLOSE;
            end else if (vc_ff < VC_MAX) begin
               term_close_in = 1'b0;
               ph_in         = 2'd0;
               state_in      = ST_TERM;
            end else begin
               state_in = ST_CLOSE;   // vertex dropped
            end
         end

         ST_TERM: begin
            ph_in = ph_ff + 2'd1;
            if (ph_ff != 2'd0) begin
               acc_in[acc_idx] = acc_ff[acc_idx] + prod_ff[55:0];
            end
            if (ph_ff == 2'd3) begin
               if (term_close_ff) begin
                  state_in = ST_MAG;
               end else begin
                  prev_in  = vtx;
                  vc_in    = vc_ff + mfec_pkg::VC_W'(1);
                  state_in = ST_CLOSE;
               end
            end
         end

         ST_CLOSE: begin
            if (item_ff.face_end || item_ff.edge_end) begin
               if (vc_ff >= VC_MIN_FACE) begin
                  term_close_in = 1'b1;
                  ph_in         = 2'd0;
                  state_in      = ST_TERM;
               end else begin
                  face_ok_in = 1'b0;
                  state_in   = ST_EDGE;
               end
            end else begin
               state_in = ST_FINISH;
            end
         end

         ST_MAG: begin
            for (int i = 0; i < 3; i++) begin
               neg_in[i] = acc_ff[i][55];
               mag_in[i] = acc_ff[i][55] ? 56'(-acc_ff[i]) : 56'(acc_ff[i]);
            end
            if (acc_ff[0] == '0 && acc_ff[1] == '0 && acc_ff[2] == '0) begin
               face_ok_in = 1'b0;
               state_in   = ST_EDGE;
            end else begin
               state_in = ST_SHIFT;
            end
         end

         ST_SHIFT: begin
            // bring the largest magnitude into [2^30, 2^31)
            if (mag_or[55:31] != '0) begin
               for (int i = 0; i < 3; i++) mag_in[i] = mag_ff[i] >> 1;
            end else if (!mag_or[30]) begin
               for (int i = 0; i < 3; i++) mag_in[i] = mag_ff[i] << 1;
            end else begin
               sum_in   = '0;
               ph_in    = 2'd0;
               state_in = ST_SQ;
            end
         end

         ST_SQ: begin
            ph_in = ph_ff + 2'd1;
            if (ph_ff != 2'd0) begin
               sum_in = sum_ff + prod_ff;
            end
            if (ph_ff == 2'd3) begin
               start_in = 1'b1;
               state_in = ST_ROOT;
            end
         end

         ST_ROOT: begin
            if (rdu_sts.done) begin
               len_in   = rdu_sts.result;
               idx_in   = 2'd0;
               start_in = 1'b1;
               state_in = ST_DIV;
            end
         end

         ST_DIV: begin
            if (rdu_sts.done) begin
               unit_in[idx_ff] = neg_ff[idx_ff] ? -$signed(quo) : $signed(quo);
               if (idx_ff == 2'd2) begin
                  face_ok_in = 1'b1;
                  state_in   = ST_EDGE;
               end else begin
                  idx_in   = idx_ff + 2'd1;
                  start_in = 1'b1;
               end
            end
         end

         ST_EDGE: begin
            for (int i = 0; i < 3; i++) begin
               acc_in[i]   = '0;
               first_in[i] = '0;
               prev_in[i]  = '0;
            end
            vc_in = '0;
            if (!item_ff.face_select) begin
               for (int i = 0; i < 3; i++) saved_in[i] = face_ok_ff ? unit_ff[i] : 32'sd0;
               ffd_in   = !face_ok_ff;
               state_in = ST_FINISH;
            end else if (item_ff.edge_end && face_ok_ff && first_ok) begin
               dot_in   = '0;
               ph_in    = 2'd0;
               state_in = ST_DOT;
            end else begin
               state_in = ST_FINISH;
            end
         end

         ST_DOT: begin
            ph_in = ph_ff + 2'd1;
            if (ph_ff != 2'd0) begin
               dot_in = dot_ff + prod_ff;
            end
            if (ph_ff == 2'd3) begin
               have_dot_in = 1'b1;
               state_in    = ST_FINISH;
            end
         end

         ST_FINISH: begin
            if (!cls_valid || !rsp_valid_ff || rsp_ready) begin
               if (cls_valid) begin
                  rsp_valid_in        = 1'b1;
                  rsp_in.edge_out     = item_ff.edge_number;
                  rsp_in.point_a_out  = item_ff.endpoint_a;
                  rsp_in.point_b_out  = item_ff.endpoint_b;
                  rsp_in.edge_class   = cls;
               end
               if (item_ff.face_count != 4'd2 || item_ff.edge_end) begin
                  for (int i = 0; i < 3; i++) begin
                     acc_in[i]   = '0;
                     first_in[i] = '0;
                     prev_in[i]  = '0;
                     saved_in[i] = '0;
                  end
                  vc_in  = '0;
                  ffd_in = 1'b0;
               end
               state_in = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cos_ff       <= mfec_pkg::COSINE_RESET;
         be_ff        <= 1'b1;
         ne_ff        <= 1'b1;
         fe_ff        <= 1'b1;
         me_ff        <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            acc_ff[i]   <= '0;
            first_ff[i] <= '0;
            prev_ff[i]  <= '0;
            saved_ff[i] <= '0;
         end
         vc_ff        <= '0;
         ffd_ff       <= 1'b0;
         have_dot_ff  <= 1'b0;
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cos_ff       <= cos_in;
         be_ff        <= be_in;
         ne_ff        <= ne_in;
         fe_ff        <= fe_in;
         me_ff        <= me_in;
         acc_ff       <= acc_in;
         first_ff     <= first_in;
         prev_ff      <= prev_in;
         saved_ff     <= saved_in;
         vc_ff        <= vc_in;
         ffd_ff       <= ffd_in;
         have_dot_ff  <= have_dot_in;
         start_ff     <= start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff       <= item_in;
      mag_ff        <= mag_in;
      neg_ff        <= neg_in;
      unit_ff       <= unit_in;
      sum_ff        <= sum_in;
      len_ff        <= len_in;
      dot_ff        <= dot_in;
      prod_ff       <= mul_a * mul_b;
      ph_ff         <= ph_in;
      idx_ff        <= idx_in;
      term_close_ff <= term_close_in;
      face_ok_ff    <= face_ok_in;
      rsp_ff        <= rsp_in;
   end

   `MFEC_ASSERT_IMPLY(a_done_while_waiting, clock, reset, rdu_sts.done, (state_ff == ST_ROOT) || (state_ff == ST_DIV), "root/divide result outside wait state")
   `MFEC_ASSERT_IMPLY(a_vertex_count_bound, clock, reset, 1'b1, vc_ff <= VC_MAX, "vertex count past face limit")
   `MFEC_ASSERT_NEXT(a_start_single_pulse, clock, reset, start_ff, !start_ff, "unit start held longer than one cycle")

endmodule
`default_nettype wire
